FILE: sv/sbll_pkg.sv
// ----------------------------------------------------------------------------
// sbll_pkg
// Shared types and codes for the seat booking list: request and response
// payloads, mode and status codes, and the controller states.
// ----------------------------------------------------------------------------
package sbll_pkg;

   // default number of seats
   localparam int SEATS_DEF = 16;

   // request modes
   localparam logic [1:0] MODE_BOOK   = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   // response status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_TAKEN      = 3'd1;
   localparam logic [2:0] STAT_EMPTY      = 3'd2;
   localparam logic [2:0] STAT_NOT_BOOKED = 3'd3;
   localparam logic [2:0] STAT_BAD_SEAT   = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] seat;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] listed_seat;
      logic       last;
      logic [4:0] free_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIST_RD,
      ST_LIST_OUT,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SEAT_RD,
      ST_UNLINK
   } ctrl_state_type;

endpackage

FILE: sv/sbll_ram.sv
// ----------------------------------------------------------------------------
// sbll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/sbll_ctrl.sv
// ----------------------------------------------------------------------------
// sbll_ctrl
// Sequencer for the seat booking list: keeps head, tail, free count and the
// booked flags, and walks the link table held in the RAM.
// ----------------------------------------------------------------------------
module sbll_ctrl import sbll_pkg::*; #(
   parameter int SEATS = SEATS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  req_type                    req_item,
   output logic                       busy,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item,
   output logic                       ram_wr_en,
   output logic [$clog2(SEATS+1)-1:0] ram_wr_addr,
   output logic [$clog2(SEATS+1)-1:0] ram_wr_data,
   output logic [$clog2(SEATS+1)-1:0] ram_rd_addr,
   input  logic [$clog2(SEATS+1)-1:0] ram_rd_data
);

   localparam int SEAT_W = $clog2(SEATS + 1);

   ctrl_state_type    state_ff, state_in;
   logic [SEAT_W-1:0] head_ff, head_in;
   logic [SEAT_W-1:0] tail_ff, tail_in;
   logic [SEAT_W-1:0] free_ff, free_in;
   logic [SEATS:0]    booked_ff, booked_in;
   logic [SEAT_W-1:0] seat_ff, seat_in;
   logic [SEAT_W-1:0] cur_ff, cur_in;
   logic              is_head_ff, is_head_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              seat_ok;
   logic [SEAT_W-1:0] seat_idx;
   logic [SEAT_W-1:0] list_next;

   // decode the request; the end of the list is found by comparing with the
   // tail, so a link is always written (on append or unlink) before it is used
   assign accept    = start && (state_ff == ST_IDLE);
   assign seat_ok   = (req_item.seat != '0) && (int'(req_item.seat) <= SEATS);
   assign seat_idx  = SEAT_W'(req_item.seat);
   assign list_next = (cur_ff == tail_ff) ? '0 : ram_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_item.mode == MODE_LIST) begin
                  if (head_ff != '0) state_in = ST_LIST_RD;
               end else if (req_item.mode == MODE_CANCEL && seat_ok && head_ff != '0
                            && booked_ff[seat_idx]) begin
                  if (seat_idx != head_ff) state_in = ST_WALK_RD;
                  else if (seat_idx != tail_ff) state_in = ST_SEAT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIST_RD:  state_in = ST_LIST_OUT;
         ST_LIST_OUT: state_in = (list_next == '0) ? ST_IDLE : ST_LIST_RD;
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: state_in = (ram_rd_data == seat_ff) ? ST_SEAT_RD : ST_WALK_RD;
         ST_SEAT_RD:  state_in = ST_UNLINK;
         ST_UNLINK:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath, RAM access and result transfer
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      booked_in    = booked_ff;
      seat_in      = seat_ff;
      cur_in       = cur_ff;
      is_head_in   = is_head_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_ff;
      ram_wr_data  = seat_idx;
      ram_rd_addr  = (state_ff == ST_SEAT_RD) ? seat_ff : cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.status      = STAT_OK;
               rsp_in.listed_seat = req_item.seat;
               rsp_in.last        = 1'b1;
               rsp_in.free_count  = 5'(free_ff);
               priority if (req_item.mode == MODE_NONE) begin
                  rsp_valid_in = 1'b0;
               end else if (req_item.mode == MODE_LIST) begin
                  // empty list gives a single status; otherwise start the walk
                  cur_in = head_ff;
                  if (head_ff == '0) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.status      = STAT_EMPTY;
                     rsp_in.listed_seat = '0;
                  end
               end else if (!seat_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STAT_BAD_SEAT;
               end else if (req_item.mode == MODE_BOOK) begin
                  rsp_valid_in = 1'b1;
                  if (booked_ff[seat_idx]) begin
                     rsp_in.status = STAT_TAKEN;
                  end else begin
                     // append at the tail
                     if (head_ff == '0) head_in = seat_idx;
                     else ram_wr_en = 1'b1;
                     tail_in             = seat_idx;
                     booked_in[seat_idx] = 1'b1;
                     free_in             = free_ff - SEAT_W'(1);
                     rsp_in.free_count   = 5'(free_ff - SEAT_W'(1));
                  end
               end else begin
                  seat_in    = seat_idx;
                  cur_in     = head_ff;
                  is_head_in = (seat_idx == head_ff);
                  priority if (head_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STAT_EMPTY;
                  end else if (!booked_ff[seat_idx]) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STAT_NOT_BOOKED;
                  end else if (seat_idx == head_ff && seat_idx == tail_ff) begin
                     // drop the only entry
                     rsp_valid_in        = 1'b1;
                     head_in             = '0;
                     tail_in             = '0;
                     booked_in[seat_idx] = 1'b0;
                     free_in             = free_ff + SEAT_W'(1);
                     rsp_in.free_count   = 5'(free_ff + SEAT_W'(1));
                  end else begin
                     rsp_valid_in = 1'b0;
                  end
               end
            end
         end
         ST_LIST_RD: begin
         end
         ST_LIST_OUT: begin
            // emit one booked seat and advance
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.listed_seat = 5'(cur_ff);
            rsp_in.last        = (list_next == '0);
            rsp_in.free_count  = 5'(free_ff);
            cur_in             = list_next;
         end
         ST_WALK_RD: begin
         end
         ST_WALK_CHK: begin
            // hold the predecessor once its link points at the seat
            if (ram_rd_data != seat_ff) cur_in = ram_rd_data;
         end
         ST_SEAT_RD: begin
         end
         ST_UNLINK: begin
            // bypass the seat, then free it
            if (is_head_ff) begin
               head_in = ram_rd_data;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff;
               ram_wr_data = ram_rd_data;
               if (tail_ff == seat_ff) tail_in = cur_ff;
            end
            booked_in[seat_ff] = 1'b0;
            free_in            = free_ff + SEAT_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.listed_seat = 5'(seat_ff);
            rsp_in.last        = 1'b1;
            rsp_in.free_count  = 5'(free_ff + SEAT_W'(1));
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= SEAT_W'(SEATS);
         booked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         booked_ff    <= booked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      seat_ff    <= seat_in;
      cur_ff     <= cur_in;
      is_head_ff <= is_head_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: sv/seat_booking_linked_list_top.sv
// ----------------------------------------------------------------------------
// seat_booking_linked_list_top
// Ordered list of booked seats kept as a linked list in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers on a clock edge with start high and busy low. Mode
//   book appends a seat at the tail, cancel unlinks a seat, list streams the
//   booked seats in booking order. Each response is shown for one cycle with
//   rsp_valid high; the final response of a request carries last.
// Sequencing:
//   Book, bad seat, status-only and only-seat cancel requests give their
//   response in the cycle after the transfer; busy stays low.
//   Cancel of the first seat reads its link in ST_SEAT_RD and unlinks it
//   in ST_UNLINK. Cancel of a later seat first walks the link RAM for the
//   predecessor, through ST_WALK_RD and ST_WALK_CHK per step, then reads
//   and unlinks the seat. List reads each link in ST_LIST_RD and gives its
//   seat in ST_LIST_OUT, as the RAM read is registered. The final response
//   shows in the same cycle that busy drops.
// Reset:
//   Head, tail and booked flags clear and the free count loads SEATS; the
//   link RAM needs no clearing since every link is written before it is used.
// Responses cannot be held off; the receiver must take each one as shown.
// ----------------------------------------------------------------------------
module seat_booking_linked_list_top import sbll_pkg::*; #(
   parameter int SEATS = SEATS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int SEAT_W = $clog2(SEATS + 1);

   logic              ram_wr_en;
   logic [SEAT_W-1:0] ram_wr_addr;
   logic [SEAT_W-1:0] ram_wr_data;
   logic [SEAT_W-1:0] ram_rd_addr;
   logic [SEAT_W-1:0] ram_rd_data;

   // sequencer
   sbll_ctrl #(
      .SEATS(SEATS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   // link table
   sbll_ram #(
      .WIDTH(SEAT_W),
      .DEPTH(SEATS + 1)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

FILE: sv/sbll_checker.sv
// ----------------------------------------------------------------------------
// sbll_checker
// Port-level checks for the seat booking list, bound to the top level.
// ----------------------------------------------------------------------------
module sbll_checker import sbll_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_item,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // no response in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response right after reset");

   // book transfers answer with one final response in the next cycle, busy low
   a_book_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_BOOK) |=> (rsp_valid && rsp_item.last && !busy))
      else $error("book did not answer with one final response");

   // unused mode gives nothing
   a_none_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_NONE) |=> !rsp_valid)
      else $error("unused mode produced a response");

   // the final response of a request leaves the block ready
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |-> !busy)
      else $error("busy after final response");

endmodule

bind seat_booking_linked_list_top sbll_checker u_checker (.*);
